>>> rtl/lottery_ticket_scheduler_assert.svh
// assertion macros shared by the scheduler modules
// expects clk and rst_n in the scope where a macro is used
`ifndef LOTTERY_TICKET_SCHEDULER_ASSERT_SVH
`define LOTTERY_TICKET_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LTS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lts check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define LTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lts check failed: next-cycle implication");

`endif

>>> rtl/lts_pkg.sv
// shared types and constants of the lottery ticket scheduler
// no dependencies
`default_nettype none

package lts_pkg;

    // table geometry
    localparam int SLOTS       = 64;
    localparam int TICKET_BITS = 16;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int TOTAL_W     = TICKET_BITS + IDX_W;

    // fixed field widths
    localparam int CMD_W        = 1;
    localparam int SLOT_FIELD_W = 6;
    localparam int TKT_FIELD_W  = 16;
    localparam int TICK_W       = 32;
    localparam int SUM_FIELD_W  = 22;
    localparam int SHIFT_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // seed and divider
    localparam int MAX_SHIFT = 8;
    localparam int SEED_W    = TICK_W + MAX_SHIFT;
    localparam int STEP_W    = $clog2(SEED_W + 1);

    // reset values of the registers
    localparam logic [TKT_FIELD_W-1:0] INIT_TICKETS_RST = TKT_FIELD_W'(75);
    localparam logic                   FAVOR_INIT_RST   = 1'b1;
    localparam logic [SHIFT_W-1:0]     TICK_SHIFT_RST   = SHIFT_W'(MAX_SHIFT);

    // item commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PICK  = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_TICKETS = 2'd0,
        CFG_FAVOR_INIT   = 2'd1,
        CFG_TICK_SHIFT   = 2'd2
    } lts_cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic scan_clr;   // restart table scan and accumulator
        logic sum_step;   // scan step, summing runnable tickets
        logic check;      // total is final, start draw if nonzero
        logic walk_step;  // scan step, prefix walk against the draw
        logic load_out;   // move finished result into output register
    } lts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pick;
        logic init_hit;
        logic scan_end;
        logic total_zero;
        logic div_done;
        logic walk_hit;
    } lts_status_t;

endpackage

`default_nettype wire

>>> rtl/lottery_ticket_scheduler.sv
// lottery ticket scheduler top level: port wiring of controller and datapath
// depends on lts_pkg, lts_ctrl, lts_datapath (and lts_mod below it)
//
// The scheduler keeps 64 slots, each with a runnable flag and a 16-bit ticket
// count, plus a mark that slot 0 holds the init task. Every accepted item gives
// exactly one result transfer. A write item (cmd 0) stores one slot and returns
// an all-zero result without a scan. A pick item (cmd 1) with init favoring on
// and a runnable init task in slot 0 also skips the scan: slot 0 wins, its
// tickets reload from init_tickets. Any other pick sums the runnable tickets
// with one table read per cycle (set by the single read port of the ticket
// table), checks the total, divides the shifted tick (40-bit seed) by the total
// in a one-bit-per-cycle remainder unit, and walks the prefix sum with the same
// read port; an empty lottery stops after the sum with winner_valid low. The
// block works on one item at a time: in_ready is high only while it is idle,
// and a finished result sits in the output register so the next item can be
// taken while that result waits for out_ready. Configuration registers must be
// written through cfg_we/cfg_index/cfg_data only while the block is idle; the
// user is bound by this, the block itself does not enforce it. Unlisted indexes
// are ignored. There is no clearing pass after reset: runnable flags reset to
// zero and ticket entries are only read behind a set flag.
`default_nettype none

module lottery_ticket_scheduler (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // item input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [lts_pkg::CMD_W-1:0]         cmd,
    input  wire logic [lts_pkg::SLOT_FIELD_W-1:0]  slot,
    input  wire logic                              runnable,
    input  wire logic [lts_pkg::TKT_FIELD_W-1:0]   tickets,
    input  wire logic                              holds_init,
    input  wire logic [lts_pkg::TICK_W-1:0]        tick_value,
    // result output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   winner_valid,
    output logic [lts_pkg::SLOT_FIELD_W-1:0]       winner_slot,
    output logic [lts_pkg::SUM_FIELD_W-1:0]        ticket_total,
    output logic [lts_pkg::SUM_FIELD_W-1:0]        winning_ticket,
    output logic                                   via_init,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [lts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lts_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lts_pkg::*;

    // command and status between the two halves
    lts_cmd_t    ctl;
    lts_status_t st;

    // sequencing: accept, sum, check, divide, walk, result handoff
    lts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .ctl       (ctl)
    );

    // table, flags, registers, scan accumulator, divider, output register
    lts_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .st             (st),
        .cmd            (cmd),
        .slot           (slot),
        .runnable       (runnable),
        .tickets        (tickets),
        .holds_init     (holds_init),
        .tick_value     (tick_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .winner_valid   (winner_valid),
        .winner_slot    (winner_slot),
        .ticket_total   (ticket_total),
        .winning_ticket (winning_ticket),
        .via_init       (via_init)
    );

endmodule

`default_nettype wire

>>> rtl/lts_mod.sv
// iterative remainder unit, one quotient bit per cycle
// depends on lts_pkg and the assertion macro header
`default_nettype none
`include "lottery_ticket_scheduler_assert.svh"

module lts_mod (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [lts_pkg::SEED_W-1:0]   dividend,
    input  wire logic [lts_pkg::TOTAL_W-1:0]  divisor,
    output logic                              done,
    output logic [lts_pkg::TOTAL_W-1:0]       rem
);
    import lts_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SEED_W-1:0]   quo_reg, quo_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [TOTAL_W-1:0]  div_reg, div_next;
    logic [TOTAL_W:0]    trial;

    assign trial = {rem_reg, quo_reg[SEED_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // restoring step
            if (trial >= {1'b0, div_reg})
                rem_next = TOTAL_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[TOTAL_W-1:0];
            quo_next  = {quo_reg[SEED_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SEED_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `LTS_ASSERT_NOW(a_rem_below_divisor, done_reg, rem_reg < div_reg)
    `LTS_ASSERT_NEXT(a_done_ends_busy, done_reg, !busy_reg || $past(start))

endmodule

`default_nettype wire

>>> rtl/lts_datapath.sv
// scheduler datapath: slot table, flags, registers, scan and result
// depends on lts_pkg, lts_mod and the assertion macro header
`default_nettype none
`include "lottery_ticket_scheduler_assert.svh"

module lts_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lts_pkg::lts_cmd_t                 ctl,
    output lts_pkg::lts_status_t                   st,
    input  wire logic [lts_pkg::CMD_W-1:0]         cmd,
    input  wire logic [lts_pkg::SLOT_FIELD_W-1:0]  slot,
    input  wire logic                              runnable,
    input  wire logic [lts_pkg::TKT_FIELD_W-1:0]   tickets,
    input  wire logic                              holds_init,
    input  wire logic [lts_pkg::TICK_W-1:0]        tick_value,
    input  wire logic                              cfg_we,
    input  wire logic [lts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lts_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   winner_valid,
    output logic [lts_pkg::SLOT_FIELD_W-1:0]       winner_slot,
    output logic [lts_pkg::SUM_FIELD_W-1:0]        ticket_total,
    output logic [lts_pkg::SUM_FIELD_W-1:0]        winning_ticket,
    output logic                                   via_init
);
    import lts_pkg::*;

    // configuration
    logic [TKT_FIELD_W-1:0] init_tickets_reg;
    logic                   favor_init_reg;
    logic [SHIFT_W-1:0]     tick_shift_reg;

    // table state
    logic [TICKET_BITS-1:0] ticket_mem [SLOTS];
    logic [SLOTS-1:0]       flags_reg;
    logic                   init_reg;

    // scan pipeline
    logic [CNT_W-1:0]       cnt_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [TICKET_BITS-1:0] rd_tkt_reg;
    logic                   rd_flag_reg;
    logic [TOTAL_W-1:0]     acc_reg;
    logic [TOTAL_W-1:0]     acc_next;
    logic [TOTAL_W-1:0]     addend;

    // work and result
    logic [TICK_W-1:0]      tick_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     draw_reg;
    logic [IDX_W-1:0]       win_reg;
    logic                   res_valid_reg;
    logic                   res_via_reg;
    logic                   show_numbers;

    logic                   out_valid_reg_f;
    logic [IDX_W-1:0]       out_slot_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic [TOTAL_W-1:0]     out_draw_reg;
    logic                   out_via_reg;

    // memory write port
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa;
    logic [TICKET_BITS-1:0] mem_wd;

    logic                   is_write;
    logic                   slot_ok;
    logic                   init_hit;
    logic                   stepping;
    logic                   walk_hit;
    logic [SHIFT_W-1:0]     shift_eff;
    logic [SEED_W-1:0]      seed;
    logic                   div_start;
    logic                   div_done;
    logic [TOTAL_W-1:0]     div_rem;

    assign is_write = (cmd == CMD_WRITE);
    assign slot_ok  = (32'(slot) < 32'(SLOTS));
    assign init_hit = favor_init_reg && init_reg && flags_reg[0];
    assign stepping = ctl.sum_step || ctl.walk_step;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_tickets_reg <= INIT_TICKETS_RST;
            favor_init_reg   <= FAVOR_INIT_RST;
            tick_shift_reg   <= TICK_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INIT_TICKETS: init_tickets_reg <= cfg_data;
                CFG_FAVOR_INIT:   favor_init_reg   <= cfg_data[0];
                CFG_TICK_SHIFT:   tick_shift_reg   <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ticket table writes: slot write or init reload
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = IDX_W'(slot);
        mem_wd = TICKET_BITS'(tickets);
        if (ctl.accept)
        begin
            if (is_write)
                mem_we = slot_ok;
            else if (init_hit)
            begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = TICKET_BITS'(init_tickets_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ticket_mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge clk)
    begin
        rd_tkt_reg <= ticket_mem[cnt_reg[IDX_W-1:0]];
    end

    // runnable flags and init mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            init_reg  <= 1'b0;
        end
        else if (ctl.accept)
        begin
            if (is_write)
            begin
                if (slot_ok)
                    flags_reg[IDX_W'(slot)] <= runnable;
                if (slot == '0)
                    init_reg <= holds_init;
            end
            else if (init_hit)
                flags_reg[0] <= 1'b0;
        end
        else if (walk_hit)
            flags_reg[rd_idx_reg] <= 1'b0;
    end

    // table scan: one read per cycle, read data registered in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (ctl.scan_clr)
        begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (stepping)
        begin
            if (cnt_reg < CNT_W'(SLOTS))
            begin
                cnt_reg    <= cnt_reg + CNT_W'(1);
                rd_vld_reg <= 1'b1;
            end
            else
                rd_vld_reg <= 1'b0;
        end
        else
            rd_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= cnt_reg[IDX_W-1:0];
        rd_flag_reg <= flags_reg[cnt_reg[IDX_W-1:0]];
    end

    assign addend   = rd_flag_reg ? TOTAL_W'(rd_tkt_reg) : '0;
    assign acc_next = acc_reg + addend;
    assign walk_hit = ctl.walk_step && rd_vld_reg && (acc_next > draw_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.scan_clr)
            acc_reg <= '0;
        else if (stepping && rd_vld_reg)
            acc_reg <= acc_next;
    end

    // seed and draw
    assign shift_eff = (tick_shift_reg > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT)
                                                              : tick_shift_reg;
    assign seed      = SEED_W'(tick_reg) << shift_eff;
    assign div_start = ctl.check && (acc_reg != '0);

    lts_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (seed),
        .divisor  (acc_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // work registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_via_reg   <= 1'b0;
        end
        else if (ctl.accept)
        begin
            res_valid_reg <= !is_write && init_hit;
            res_via_reg   <= !is_write && init_hit;
        end
        else if (ctl.check)
            res_valid_reg <= (acc_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
            tick_reg <= tick_value;
        if (ctl.check)
            total_reg <= acc_reg;
        if (div_done)
            draw_reg <= div_rem;
        if (walk_hit)
            win_reg <= rd_idx_reg;
    end

    // output register
    assign show_numbers = res_valid_reg && !res_via_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_valid_reg_f <= res_valid_reg;
            out_via_reg     <= res_via_reg;
            out_slot_reg    <= show_numbers ? win_reg : '0;
            out_total_reg   <= show_numbers ? total_reg : '0;
            out_draw_reg    <= show_numbers ? draw_reg : '0;
        end
    end

    assign winner_valid   = out_valid_reg_f;
    assign via_init       = out_via_reg;
    assign winner_slot    = SLOT_FIELD_W'(out_slot_reg);
    assign ticket_total   = SUM_FIELD_W'(out_total_reg);
    assign winning_ticket = SUM_FIELD_W'(out_draw_reg);

    assign st.is_pick    = (cmd == CMD_PICK);
    assign st.init_hit   = init_hit;
    assign st.scan_end   = ctl.sum_step && rd_vld_reg && (rd_idx_reg == IDX_W'(SLOTS - 1));
    assign st.total_zero = (acc_reg == '0);
    assign st.div_done   = div_done;
    assign st.walk_hit   = walk_hit;

    `LTS_ASSERT_NOW(a_prefix_within_total, ctl.walk_step, acc_reg <= total_reg)
    `LTS_ASSERT_NEXT(a_winner_flag_cleared, walk_hit, !flags_reg[$past(rd_idx_reg)])

endmodule

`default_nettype wire

>>> rtl/lts_ctrl.sv
// scheduler controller: item sequencing and output valid
// depends on lts_pkg and the assertion macro header
`default_nettype none
`include "lottery_ticket_scheduler_assert.svh"

module lts_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire lts_pkg::lts_status_t  st,
    output lts_pkg::lts_cmd_t          ctl
);
    import lts_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SUM  = 6'b000010,
        S_CHK  = 6'b000100,
        S_DIV  = 6'b001000,
        S_WALK = 6'b010000,
        S_DONE = 6'b100000
    } lts_state_t;

    lts_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    if (st.is_pick && !st.init_hit)
                    begin
                        ctl.scan_clr = 1'b1;
                        state_next   = S_SUM;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_SUM:
            begin
                ctl.sum_step = 1'b1;
                if (st.scan_end)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                ctl.check  = 1'b1;
                state_next = st.total_zero ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    ctl.scan_clr = 1'b1;
                    state_next   = S_WALK;
                end
            end
            S_WALK:
            begin
                ctl.walk_step = 1'b1;
                if (st.walk_hit)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `LTS_ASSERT_NEXT(a_div_to_walk, (state_reg == S_DIV) && st.div_done, state_reg == S_WALK)
    `LTS_ASSERT_NEXT(a_done_holds, (state_reg == S_DONE) && !out_free, state_reg == S_DONE)
    `LTS_ASSERT_NOW(a_load_needs_room, ctl.load_out, out_free)

endmodule

`default_nettype wire
